### sv/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, idle during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### sv/ldd_pkg.sv
// Shared types and constants of the light dip detector.
`default_nettype none

package ldd_pkg;

	localparam int BANK_DEPTH_DEF = 2048;
	localparam int SAMPLE_BITS    = 12;

	localparam logic [11:0] DIP_THRESHOLD_RST    = 12'd124;
	localparam logic [11:0] REARM_HYSTERESIS_RST = 12'd37;
	localparam logic [15:0] AVERAGE_GAIN_RST     = 16'd66;

	localparam logic [1:0] CFG_DIP_THRESHOLD    = 2'd0;
	localparam logic [1:0] CFG_REARM_HYSTERESIS = 2'd1;
	localparam logic [1:0] CFG_AVERAGE_GAIN     = 2'd2;

	typedef enum logic [1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_TICK   = 2'd1,
		REQ_READ   = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_kind_t;

	// Result fields known at accept time; history data follows from the RAM.
	typedef struct packed {
		logic [27:0] average;
		logic        dip_detected;
		logic [15:0] dip_count;
		logic [47:0] total_samples;
		logic [11:0] history_count;
		logic        index_valid;
	} res_early_t;

	typedef struct packed {
		logic [27:0] average;
		logic        dip_detected;
		logic [15:0] dip_count;
		logic [47:0] total_samples;
		logic [11:0] history_count;
		logic [11:0] history_data;
		logic        index_valid;
	} res_t;

endpackage

`default_nettype wire

### sv/ldd_chan_if.sv
// Request and result channel interfaces.
`default_nettype none

interface ldd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [11:0] sample;
	logic [10:0] read_index;

	modport source (output valid, req_type, sample, read_index, input ready);
	modport sink (input valid, req_type, sample, read_index, output ready);
endinterface

interface ldd_res_if;
	logic        valid;
	logic        ready;
	logic [27:0] average;
	logic        dip_detected;
	logic [15:0] dip_count;
	logic [47:0] total_samples;
	logic [11:0] history_count;
	logic [11:0] history_data;
	logic        index_valid;

	modport source (output valid, average, dip_detected, dip_count, total_samples,
		history_count, history_data, index_valid, input ready);
	modport sink (input valid, average, dip_detected, dip_count, total_samples,
		history_count, history_data, index_valid, output ready);
endinterface

`default_nettype wire

### sv/ldd_bank_ram.sv
// Ping-pong sample store: two banks, one write and one read port, registered read.
`default_nettype none

module ldd_bank_ram #(
	parameter int BANK_DEPTH = ldd_pkg::BANK_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic                          wr_bank,
	input  wire logic [$clog2(BANK_DEPTH)-1:0] wr_addr,
	input  wire logic [ldd_pkg::SAMPLE_BITS-1:0] wr_data,
	input  wire logic                          re,
	input  wire logic                          rd_bank,
	input  wire logic [$clog2(BANK_DEPTH)-1:0] rd_addr,
	output logic      [ldd_pkg::SAMPLE_BITS-1:0] rd_data
);

	logic [ldd_pkg::SAMPLE_BITS-1:0] mem [2][BANK_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_bank][wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_data <= mem[rd_bank][rd_addr];
		end
	end

endmodule

`default_nettype wire

### sv/ldd_core.sv
// Detector state, average update, dip detection and store addressing.
`default_nettype none

module ldd_core #(
	parameter int BANK_DEPTH = ldd_pkg::BANK_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [1:0]                    req_type,
	input  wire logic [11:0]                   sample,
	input  wire logic [10:0]                   read_index,
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [15:0]                   cfg_data,
	output ldd_pkg::res_early_t                res,
	output logic                               mem_we,
	output logic                               mem_wr_bank,
	output logic      [$clog2(BANK_DEPTH)-1:0] mem_wr_addr,
	output logic      [ldd_pkg::SAMPLE_BITS-1:0] mem_wr_data,
	output logic                               mem_re,
	output logic                               mem_rd_bank,
	output logic      [$clog2(BANK_DEPTH)-1:0] mem_rd_addr
);

	localparam int ADDR_W = $clog2(BANK_DEPTH);
	localparam int FILL_W = $clog2(BANK_DEPTH + 1);

	ldd_pkg::req_kind_t kind;

	logic [11:0]       thr_q;
	logic [11:0]       hyst_q;
	logic [15:0]       gain_q;
	logic [27:0]       avg_q;
	logic              first_q;
	logic              armed_q;
	logic [FILL_W-1:0] cur_fill_q;
	logic [FILL_W-1:0] hist_fill_q;
	logic              bank_q;
	logic [15:0]       dips_q;
	logic [47:0]       total_q;

	logic [27:0]        s_fix;
	logic signed [29:0] s_ext;
	logic signed [29:0] a_ext;
	logic signed [29:0] rearm_lim;
	logic signed [29:0] dip_lim;
	logic signed [28:0] diff;
	logic signed [45:0] prod;
	logic signed [29:0] step;
	logic [27:0]        avg_upd;
	logic               det_en;
	logic               rearm_hit;
	logic               dip_hit;
	logic               is_sample;
	logic               bank_room;

	logic [27:0]       avg_d;
	logic              armed_d;
	logic              first_d;
	logic [FILL_W-1:0] cur_fill_d;
	logic [FILL_W-1:0] hist_fill_d;
	logic              bank_d;
	logic [15:0]       dips_pre;
	logic [15:0]       dips_d;
	logic [47:0]       total_d;
	logic              dip_flag;
	logic              idx_ok;

	assign kind  = ldd_pkg::req_kind_t'(req_type);
	assign s_fix = {sample, 16'b0};
	assign s_ext = $signed({2'b00, s_fix});
	assign a_ext = $signed({2'b00, avg_q});

	assign rearm_lim = a_ext - $signed({2'b00, hyst_q, 16'b0});
	assign dip_lim   = a_ext - $signed({2'b00, thr_q, 16'b0});
	assign det_en    = !first_q && (cur_fill_q != '0);
	assign rearm_hit = det_en && !armed_q && (s_ext > rearm_lim);
	assign dip_hit   = det_en && armed_q && (s_ext < dip_lim);

	// avg + g*(s - avg)/2^16, floor; same as the weighted sum truncated
	assign diff    = $signed({1'b0, s_fix}) - $signed({1'b0, avg_q});
	assign prod    = diff * $signed({1'b0, gain_q});
	assign step    = 30'(prod >>> 16);
	assign avg_upd = 28'(a_ext + step);

	assign bank_room = cur_fill_q < FILL_W'(BANK_DEPTH);
	assign idx_ok    = (32'(read_index) < 32'(hist_fill_q))
		&& (32'(read_index) < 32'(BANK_DEPTH));

	always_comb begin
		avg_d       = avg_q;
		armed_d     = armed_q;
		first_d     = first_q;
		cur_fill_d  = cur_fill_q;
		hist_fill_d = hist_fill_q;
		bank_d      = bank_q;
		dips_pre    = dips_q;
		total_d     = total_q;
		dip_flag    = 1'b0;
		is_sample   = 1'b0;
		unique case (kind)
			ldd_pkg::REQ_SAMPLE: begin
				is_sample = 1'b1;
				if (rearm_hit) begin
					armed_d = 1'b1;
				end else if (dip_hit) begin
					armed_d  = 1'b0;
					dip_flag = 1'b1;
					if (dips_q != 16'hFFFF) begin
						dips_pre = dips_q + 16'd1;
					end
				end
				avg_d   = first_q ? s_fix : avg_upd;
				first_d = 1'b0;
				if (bank_room) begin
					cur_fill_d = cur_fill_q + FILL_W'(1);
				end
				total_d = total_q + 48'd1;
			end
			ldd_pkg::REQ_TICK: begin
				hist_fill_d = cur_fill_q;
				bank_d      = !bank_q;
				cur_fill_d  = '0;
			end
			ldd_pkg::REQ_READ: begin
			end
			ldd_pkg::REQ_CLEAR: begin
			end
			default: begin
			end
		endcase
		dips_d = (kind == ldd_pkg::REQ_CLEAR) ? 16'd0 : dips_pre;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= ldd_pkg::DIP_THRESHOLD_RST;
			hyst_q      <= ldd_pkg::REARM_HYSTERESIS_RST;
			gain_q      <= ldd_pkg::AVERAGE_GAIN_RST;
			avg_q       <= '0;
			first_q     <= 1'b1;
			armed_q     <= 1'b1;
			cur_fill_q  <= '0;
			hist_fill_q <= '0;
			bank_q      <= 1'b0;
			dips_q      <= '0;
			total_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ldd_pkg::CFG_DIP_THRESHOLD:    thr_q  <= cfg_data[11:0];
					ldd_pkg::CFG_REARM_HYSTERESIS: hyst_q <= cfg_data[11:0];
					ldd_pkg::CFG_AVERAGE_GAIN:     gain_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (accept) begin
				avg_q       <= avg_d;
				first_q     <= first_d;
				armed_q     <= armed_d;
				cur_fill_q  <= cur_fill_d;
				hist_fill_q <= hist_fill_d;
				bank_q      <= bank_d;
				dips_q      <= dips_d;
				total_q     <= total_d;
			end
		end
	end

	// Writes go to the live bank, reads to the other one: never the same entry.
	assign mem_we      = accept && is_sample && bank_room;
	assign mem_wr_bank = bank_q;
	assign mem_wr_addr = cur_fill_q[ADDR_W-1:0];
	assign mem_wr_data = sample;
	assign mem_re      = accept && (kind == ldd_pkg::REQ_READ);
	assign mem_rd_bank = !bank_q;
	assign mem_rd_addr = ADDR_W'(read_index);

	assign res.average       = avg_d;
	assign res.dip_detected  = dip_flag;
	assign res.dip_count     = dips_pre;
	assign res.total_samples = total_d;
	assign res.history_count = 12'(hist_fill_d);
	assign res.index_valid   = (kind == ldd_pkg::REQ_READ) && idx_ok;

endmodule

`default_nettype wire

### sv/ldd_out_stage.sv
// Read-wait stage and output register with request flow control.
`default_nettype none

module ldd_out_stage (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            accept,
	output logic                                 in_ready,
	input  wire ldd_pkg::res_early_t             res_in,
	input  wire logic [ldd_pkg::SAMPLE_BITS-1:0] rd_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output ldd_pkg::res_t                        res_out
);

	logic                valid_s1;
	ldd_pkg::res_early_t res_s1;
	logic                out_valid_q;
	ldd_pkg::res_t       res_q;
	logic                adv;

	// RAM data is only reloaded on accept, so it holds while this stage waits.
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_in;
		end
		if (adv) begin
			res_q.average       <= res_s1.average;
			res_q.dip_detected  <= res_s1.dip_detected;
			res_q.dip_count     <= res_s1.dip_count;
			res_q.total_samples <= res_s1.total_samples;
			res_q.history_count <= res_s1.history_count;
			res_q.history_data  <= res_s1.index_valid ? 12'(rd_data) : 12'd0;
			res_q.index_valid   <= res_s1.index_valid;
		end
	end

	assign out_valid = out_valid_q;
	assign res_out   = res_q;

endmodule

`default_nettype wire

### sv/light_dip_detector_with_average.sv
// Light dip detector: exponential average, hysteresis dip detection, ping-pong history.
// Path: accepted requests pass the read-wait stage, then the output register, to res_ch.
// Throughput: one request per cycle while res_ch does not stall; all state updates at the
// accept edge, so the average recurrence (one 29x17 multiply and add) is combinational.
// Reset: arst_n clears all control state asynchronously; the sample store is not cleared.
`default_nettype none

module light_dip_detector_with_average #(
	parameter int BANK_DEPTH = ldd_pkg::BANK_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ldd_req_if.sink          req_ch,
	ldd_res_if.source        res_ch,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int ADDR_W = $clog2(BANK_DEPTH);

	logic                accept;
	logic                in_ready;
	ldd_pkg::res_early_t res_early;
	ldd_pkg::res_t       res_out;

	logic                          mem_we;
	logic                          mem_wr_bank;
	logic [ADDR_W-1:0]             mem_wr_addr;
	logic [ldd_pkg::SAMPLE_BITS-1:0] mem_wr_data;
	logic                          mem_re;
	logic                          mem_rd_bank;
	logic [ADDR_W-1:0]             mem_rd_addr;
	logic [ldd_pkg::SAMPLE_BITS-1:0] mem_rd_data;

	assign req_ch.ready = in_ready;
	assign accept       = req_ch.valid && in_ready;

	ldd_core #(
		.BANK_DEPTH(BANK_DEPTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.req_type   (req_ch.req_type),
		.sample     (req_ch.sample),
		.read_index (req_ch.read_index),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.res        (res_early),
		.mem_we     (mem_we),
		.mem_wr_bank(mem_wr_bank),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.mem_re     (mem_re),
		.mem_rd_bank(mem_rd_bank),
		.mem_rd_addr(mem_rd_addr)
	);

	ldd_bank_ram #(
		.BANK_DEPTH(BANK_DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (mem_we),
		.wr_bank(mem_wr_bank),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.re     (mem_re),
		.rd_bank(mem_rd_bank),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	ldd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_ready (in_ready),
		.res_in   (res_early),
		.rd_data  (mem_rd_data),
		.out_valid(res_ch.valid),
		.out_ready(res_ch.ready),
		.res_out  (res_out)
	);

	assign res_ch.average       = res_out.average;
	assign res_ch.dip_detected  = res_out.dip_detected;
	assign res_ch.dip_count     = res_out.dip_count;
	assign res_ch.total_samples = res_out.total_samples;
	assign res_ch.history_count = res_out.history_count;
	assign res_ch.history_data  = res_out.history_data;
	assign res_ch.index_valid   = res_out.index_valid;

endmodule

`default_nettype wire

### sv/ldd_checker.sv
// Port-level checker for the light dip detector, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module ldd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [27:0] average,
	input wire logic        dip_detected,
	input wire logic [15:0] dip_count,
	input wire logic [11:0] history_data,
	input wire logic        index_valid
);

	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)
	`ASSERT_NEXT(a_avg_hold, clk, arst_n, res_valid && !res_ready, $stable(average))
	`ASSERT_IMPLIES(a_dip_counted, clk, arst_n, res_valid && dip_detected, dip_count != 16'd0)
	`ASSERT_IMPLIES(a_dip_not_read, clk, arst_n, res_valid && dip_detected, !index_valid)
	`ASSERT_IMPLIES(a_bad_idx_zero, clk, arst_n, res_valid && !index_valid,
		history_data == 12'd0)

endmodule

bind light_dip_detector_with_average ldd_checker u_ldd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res_ch.valid),
	.res_ready   (res_ch.ready),
	.average     (res_ch.average),
	.dip_detected(res_ch.dip_detected),
	.dip_count   (res_ch.dip_count),
	.history_data(res_ch.history_data),
	.index_valid (res_ch.index_valid)
);

`default_nettype wire
